>>> hdl/efs_pkg.sv
package efs_pkg;

	localparam int VALUE_W = 32;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] sorted_value;
		logic                      final_res;
		logic                      overflow;
	} out_item_t;

	// per-cycle command broadcast along a chain
	typedef struct packed {
		logic ins;
		logic shift;
		logic desc;
	} cell_ctl_t;

	typedef enum logic {
		ST_COLLECT,
		ST_DRAIN
	} state_t;

	localparam int  PADDR_W       = 3;
	localparam logic REG_DESC_MODE = 1'b0;

	// true when a belongs ahead of b: even before odd, then by value
	function automatic logic goes_before(
		input logic signed [VALUE_W-1:0] a,
		input logic signed [VALUE_W-1:0] b,
		input logic                      desc
	);
		logic a_even;
		logic b_even;
		a_even = ~a[0];
		b_even = ~b[0];
		if (a_even != b_even) begin
			return a_even;
		end
		return desc ? (a > b) : (a < b);
	endfunction

endpackage

>>> hdl/efs_cell.sv
module efs_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  efs_pkg::cell_ctl_t                  ctl,
	input  logic signed [efs_pkg::VALUE_W-1:0]  x,
	input  logic signed [efs_pkg::VALUE_W-1:0]  prev_value,
	input  logic                                prev_valid,
	input  logic                                prev_ahead,
	input  logic signed [efs_pkg::VALUE_W-1:0]  next_value,
	input  logic                                next_valid,
	output logic signed [efs_pkg::VALUE_W-1:0]  value,
	output logic                                valid,
	output logic                                ahead
);

	logic signed [efs_pkg::VALUE_W-1:0] value_q;
	logic                               valid_q;

	// an empty cell always accepts; chain order keeps this monotone
	assign ahead = !valid_q || efs_pkg::goes_before(x, value_q, ctl.desc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= next_valid;
		end else if (ctl.ins && ahead) begin
			valid_q <= prev_ahead ? prev_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			value_q <= next_value;
		end else if (ctl.ins && ahead) begin
			// take the neighbor's value when the new item lands further up
			value_q <= prev_ahead ? prev_value : x;
		end
	end

	assign value = value_q;
	assign valid = valid_q;

endmodule

>>> hdl/efs_chain.sv
module efs_chain #(
	parameter int MAX_ITEMS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  efs_pkg::cell_ctl_t                  ctl,
	input  logic signed [efs_pkg::VALUE_W-1:0]  x,
	output logic signed [efs_pkg::VALUE_W-1:0]  head_value,
	output logic                                head_valid
);

	logic signed [efs_pkg::VALUE_W-1:0] value_w  [MAX_ITEMS];
	logic                               valid_w  [MAX_ITEMS];
	logic                               ahead_w  [MAX_ITEMS];

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic signed [efs_pkg::VALUE_W-1:0] prev_value;
		logic                               prev_valid;
		logic                               prev_ahead;
		logic signed [efs_pkg::VALUE_W-1:0] next_value;
		logic                               next_valid;

		if (i == 0) begin : g_head
			assign prev_value = '0;
			assign prev_valid = 1'b0;
			assign prev_ahead = 1'b0;
		end else begin : g_body
			assign prev_value = value_w[i-1];
			assign prev_valid = valid_w[i-1];
			assign prev_ahead = ahead_w[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_tail
			assign next_value = '0;
			assign next_valid = 1'b0;
		end else begin : g_mid
			assign next_value = value_w[i+1];
			assign next_valid = valid_w[i+1];
		end

		efs_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.x          (x),
			.prev_value (prev_value),
			.prev_valid (prev_valid),
			.prev_ahead (prev_ahead),
			.next_value (next_value),
			.next_valid (next_valid),
			.value      (value_w[i]),
			.valid      (valid_w[i]),
			.ahead      (ahead_w[i])
		);
	end

	assign head_value = value_w[0];
	assign head_valid = valid_w[0];

endmodule

>>> hdl/even_first_sorter_core.sv
// Channel   | Handshake               | Payload
// ----------+-------------------------+--------------------------------------
// item      | item_valid / item_ready | efs_pkg::in_item_t  (value, last)
// res       | res_valid / res_ready   | efs_pkg::out_item_t (sorted_value,
//           |                         |   final_res, overflow)
// config    | APB write/read          | descending_mode at byte address 0
//
// One input item per cycle while collecting: each item taken while not full
// is inserted into two compare-cell chains (one per sort direction).
// The item flagged last starts a drain of n results, one per cycle while
// res_ready is high, shifted out of the head cell of the chain that matches
// descending_mode; no input item is taken until the last result is accepted.
// Reset clears the cell valid bits, count, drop flag and mode at once.
// A stall on res holds the head cell and the count.
module even_first_sorter_core #(
	parameter int MAX_ITEMS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  efs_pkg::in_item_t             item,
	output logic                          res_valid,
	input  logic                          res_ready,
	output efs_pkg::out_item_t            res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [efs_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	efs_pkg::state_t    state_q;
	efs_pkg::state_t    state_nxt;
	logic [CNT_W-1:0]   count_q;
	logic               dropped_q;
	logic               desc_mode_q;
	logic               sel_desc_q;
	logic               full;
	logic               item_acc;
	logic               res_acc;
	logic               res_done;
	efs_pkg::cell_ctl_t ctl_asc;
	efs_pkg::cell_ctl_t ctl_dsc;
	logic signed [efs_pkg::VALUE_W-1:0] head_asc;
	logic signed [efs_pkg::VALUE_W-1:0] head_dsc;
	logic               valid_asc;
	logic               valid_dsc;
	logic               reg_hit;

	// configuration port
	assign pready  = 1'b1;
	assign reg_hit = (paddr[efs_pkg::PADDR_W-1] == efs_pkg::REG_DESC_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			desc_mode_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_hit) begin
			prdata[0] = desc_mode_q;
		end
	end

	// handshake
	assign item_acc = item_valid && item_ready;
	assign res_acc  = res_valid && res_ready;
	assign full     = (count_q == CNT_W'(MAX_ITEMS));
	assign res_done = res_acc && (count_q == CNT_W'(1));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			efs_pkg::ST_COLLECT: begin
				if (item_acc && item.last) begin
					state_nxt = efs_pkg::ST_DRAIN;
				end
			end
			efs_pkg::ST_DRAIN: begin
				if (res_done) begin
					state_nxt = efs_pkg::ST_COLLECT;
				end
			end
			default: state_nxt = efs_pkg::ST_COLLECT;
		endcase
	end

	always_comb begin
		item_ready = 1'b0;
		res_valid  = 1'b0;
		case (state_q)
			efs_pkg::ST_COLLECT: item_ready = 1'b1;
			efs_pkg::ST_DRAIN:   res_valid  = 1'b1;
			default: begin
				item_ready = 1'b0;
				res_valid  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= efs_pkg::ST_COLLECT;
			count_q    <= '0;
			dropped_q  <= 1'b0;
			sel_desc_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (item_acc) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
				if (item.last) begin
					sel_desc_q <= desc_mode_q;
				end
			end else if (res_acc) begin
				count_q <= count_q - CNT_W'(1);
				if (res_done) begin
					dropped_q <= 1'b0;
				end
			end
		end
	end

	// both chains insert every item taken while not full; drain picks one
	always_comb begin
		ctl_asc.ins   = item_acc && !full;
		ctl_asc.shift = res_acc;
		ctl_asc.desc  = 1'b0;
		ctl_dsc       = ctl_asc;
		ctl_dsc.desc  = 1'b1;
	end

	efs_chain #(.MAX_ITEMS(MAX_ITEMS)) u_chain_asc (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl_asc),
		.x          (item.value),
		.head_value (head_asc),
		.head_valid (valid_asc)
	);

	efs_chain #(.MAX_ITEMS(MAX_ITEMS)) u_chain_dsc (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl_dsc),
		.x          (item.value),
		.head_value (head_dsc),
		.head_valid (valid_dsc)
	);

	always_comb begin
		res.sorted_value = sel_desc_q ? head_dsc : head_asc;
		res.final_res    = (count_q == CNT_W'(1));
		res.overflow     = dropped_q;
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(item_ready && res_valid))
		else $error("item_ready and res_valid high together");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (count_q != '0) && valid_asc && valid_dsc)
		else $error("drain with empty chain");

	a_last_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && item.last) |=> res_valid)
		else $error("last item did not start drain");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS))
		else $error("element count beyond capacity");

	a_chains_agree: assert property (@(posedge clk) disable iff (!arst_n)
		valid_asc == valid_dsc)
		else $error("chains out of step");

endmodule
